### design/lcpd_pkg.sv
package lcpd_pkg;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_STALE_TICKS = 1'b1;

    localparam logic [9:0]  RST_MAX_PAYLOAD = 10'd508;
    localparam logic [15:0] RST_STALE_TICKS = 16'd10000;

    localparam logic [10:0] GARBAGE_SLACK = 11'd10;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [10:0] BSG_MAX       = 11'h7FF;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [9:0]  FLEN_MAX      = 10'h3FF;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_LEN_HI  = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC_HI  = 3'd3,
        PH_CRC_LO  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_CRC_BAD = 3'd2,
        KIND_BAD_LEN = 3'd3,
        KIND_RESET   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [9:0] frame_length;
    } t_result;

    // results caused by one input transfer; r1 is used only when two is set
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_group;

    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [9:0] sat_len(logic [15:0] v);
        return (v > {6'd0, FLEN_MAX}) ? FLEN_MAX : v[9:0];
    endfunction

endpackage

### design/lcpd_in_if.sv
interface lcpd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

### design/lcpd_out_if.sv
interface lcpd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [9:0] frame_length;
    logic       last;

    modport source (output valid, output kind, output payload_byte, output frame_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_length,
                    input last, output ready);
endinterface

### design/length_crc_packet_deframer.sv
// Length-prefixed frame deframer with CRC-16/MODBUS check.
// i_in: one transfer per received byte, millisecond tick or flush request.
// o_out: result transfers (payload byte, frame good, CRC bad, bad length,
//   stale/garbage reset); last marks the final result of one input transfer.
// APB port: max_payload at 0x0, stale_ticks at 0x4; write only while idle.
// A result is written into the result queue and offered from its head.
// Throughput: one input per cycle while the queue is not full; the parser
//   updates all state combinationally (byte-wide CRC XOR network). An input
//   with two results is offered as two output transfers.
// A four-entry result queue sits between parser and output, so inputs keep
//   flowing while a result waits; i_in.ready drops only when it is full.
// Reset: parser back to awaiting the length high byte, queue emptied,
//   registers to 508 and 10000.
module length_crc_packet_deframer import lcpd_pkg::*; #(
    parameter int LEN_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcpd_in_if.sink     i_in,
    lcpd_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0]  r_max_payload;
    logic [15:0] r_stale_ticks;
    logic        cfg_wr;
    logic        take;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_group      group;
    t_group      head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_STALE_TICKS) ? {16'd0, r_stale_ticks}
                                                  : {22'd0, r_max_payload};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= RST_MAX_PAYLOAD;
            r_stale_ticks <= RST_STALE_TICKS;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_PAYLOAD) begin
                r_max_payload <= pwdata[9:0];
            end else begin
                r_stale_ticks <= pwdata[15:0];
            end
        end
    end

    assign i_in.ready = !full;
    assign take       = i_in.valid && !full;

    lcpd_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_action      (i_in.action),
        .i_rx_byte     (i_in.rx_byte),
        .i_max_payload (r_max_payload),
        .i_stale_ticks (r_stale_ticks),
        .o_push        (push),
        .o_group       (group)
    );

    lcpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (group),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    lcpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

`ifndef SYNTH
    a_reset_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_RESET) |-> o_out.last)
        else $error("reset result not final");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("second result missing");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != KIND_PAYLOAD) |-> (o_out.payload_byte == 8'd0))
        else $error("nonzero byte on status result");
`endif

endmodule

### design/lcpd_front.sv
module lcpd_front import lcpd_pkg::*; #(
    parameter int LEN_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [9:0]  i_max_payload,
    input  logic [15:0] i_stale_ticks,
    output logic        o_push,
    output t_group      o_group
);

    localparam logic [15:0] LEN_MAX = 16'((32'd1 << LEN_BITS) - 32'd1);

    t_phase                r_phase, n_phase;
    logic [15:0]           r_exp_len, n_exp_len;
    logic [LEN_BITS-1:0]   r_cnt, n_cnt;
    logic [15:0]           r_crc, n_crc;
    logic [7:0]            r_crc_hi, n_crc_hi;
    logic [10:0]           r_bsg, n_bsg;
    logic [15:0]           r_idle, n_idle;
    logic                  r_held, n_held;

    logic [15:0]         eff_max;
    logic [15:0]         len_val;
    logic                len_ok;
    logic [LEN_BITS-1:0] cnt_inc;
    logic                cnt_done;
    logic [10:0]         bsg_inc;
    logic [10:0]         bsg_byte;
    logic [15:0]         idle_inc;
    logic                crc_good;
    logic                post_pay;
    logic                is_byte, is_tick, is_flush;
    logic                drop_len, garbage, stale, drop_any;

    assign is_byte  = i_take && (i_action == ACT_BYTE);
    assign is_tick  = i_take && (i_action == ACT_TICK);
    assign is_flush = i_take && (i_action == ACT_FLUSH);

    assign eff_max  = ({6'd0, i_max_payload} < LEN_MAX) ? {6'd0, i_max_payload} : LEN_MAX;
    assign len_val  = r_exp_len | {8'h00, i_rx_byte};
    assign len_ok   = (len_val != 16'd0) && (len_val <= eff_max);
    assign cnt_inc  = r_cnt + 1'b1;
    assign cnt_done = 16'(cnt_inc) >= r_exp_len;
    assign bsg_inc  = (r_bsg == BSG_MAX) ? r_bsg : r_bsg + 11'd1;
    assign idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign crc_good = {r_crc_hi, i_rx_byte} == r_crc;
    assign post_pay = (r_phase == PH_LEN_LO && len_ok) || r_phase == PH_PAYLOAD
                   || r_phase == PH_CRC_HI;

    // byte count after this byte, before any drop
    assign bsg_byte = (r_phase >= PH_CRC_LO && crc_good) ? 11'd0 : bsg_inc;

    assign drop_len = is_byte && (r_phase == PH_LEN_LO) && !len_ok;
    assign garbage  = is_byte && !drop_len
                   && (bsg_byte > ({1'b0, i_max_payload} + GARBAGE_SLACK));
    assign stale    = is_tick && r_held && (idle_inc > i_stale_ticks);
    assign drop_any = drop_len || garbage || stale || is_flush;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (drop_any) begin
            n_phase = PH_LEN_HI;
        end else if (is_byte) begin
            unique case (r_phase)
                PH_LEN_HI:  n_phase = PH_LEN_LO;
                PH_LEN_LO:  n_phase = PH_PAYLOAD;
                PH_PAYLOAD: n_phase = cnt_done ? PH_CRC_HI : PH_PAYLOAD;
                PH_CRC_HI:  n_phase = PH_CRC_LO;
                PH_CRC_LO:  n_phase = PH_LEN_HI;
                default:    n_phase = PH_LEN_HI;
            endcase
        end
    end

    // datapath and results
    always_comb begin
        logic emit0;
        emit0     = 1'b0;
        n_exp_len = r_exp_len;
        n_cnt     = r_cnt;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_bsg     = r_bsg;
        n_idle    = r_idle;
        n_held    = r_held;
        o_group   = '0;

        if (is_byte) begin
            n_idle = 16'd0;
            n_bsg  = bsg_inc;
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_exp_len = {i_rx_byte, 8'h00};
                    n_held    = 1'b1;
                end
                PH_LEN_LO: begin
                    n_exp_len = len_val;
                    if (!len_ok) begin
                        emit0                 = 1'b1;
                        o_group.r0.kind         = KIND_BAD_LEN;
                        o_group.r0.frame_length = sat_len(len_val);
                    end else begin
                        n_cnt = '0;
                        n_crc = CRC_SEED;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc                   = crc16_byte(r_crc, i_rx_byte);
                    n_cnt                   = cnt_inc;
                    emit0                   = 1'b1;
                    o_group.r0.kind         = KIND_PAYLOAD;
                    o_group.r0.payload_byte = i_rx_byte;
                    o_group.r0.frame_length = r_exp_len[9:0];
                end
                PH_CRC_HI: begin
                    n_crc_hi = i_rx_byte;
                end
                default: begin
                    emit0                   = 1'b1;
                    o_group.r0.kind         = crc_good ? KIND_GOOD : KIND_CRC_BAD;
                    o_group.r0.frame_length = r_exp_len[9:0];
                    n_exp_len               = 16'd0;
                    n_cnt                   = '0;
                    n_crc                   = CRC_SEED;
                    n_crc_hi                = 8'h00;
                    n_held                  = 1'b0;
                    if (crc_good) begin
                        n_bsg = 11'd0;
                    end
                end
            endcase

            if (garbage) begin
                if (emit0) begin
                    o_group.two             = 1'b1;
                    o_group.r1.kind         = KIND_RESET;
                    o_group.r1.frame_length = post_pay ? sat_len(n_exp_len) : 10'd0;
                end else begin
                    emit0                   = 1'b1;
                    o_group.r0.kind         = KIND_RESET;
                    o_group.r0.frame_length = post_pay ? sat_len(n_exp_len) : 10'd0;
                end
            end
        end else if (is_tick) begin
            n_idle = idle_inc;
            if (stale) begin
                emit0                   = 1'b1;
                o_group.r0.kind         = KIND_RESET;
                o_group.r0.frame_length = (r_phase == PH_PAYLOAD || r_phase == PH_CRC_HI
                                           || r_phase == PH_CRC_LO) ? sat_len(r_exp_len)
                                                                    : 10'd0;
            end
        end

        if (drop_any) begin
            n_exp_len = 16'd0;
            n_cnt     = '0;
            n_crc     = CRC_SEED;
            n_crc_hi  = 8'h00;
            n_bsg     = 11'd0;
            n_held    = 1'b0;
        end

        o_push = emit0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN_HI;
            r_exp_len <= 16'd0;
            r_cnt     <= '0;
            r_crc     <= CRC_SEED;
            r_crc_hi  <= 8'h00;
            r_bsg     <= 11'd0;
            r_idle    <= 16'd0;
            r_held    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_cnt     <= n_cnt;
            r_crc     <= n_crc;
            r_crc_hi  <= n_crc_hi;
            r_bsg     <= n_bsg;
            r_idle    <= n_idle;
            r_held    <= n_held;
        end
    end

endmodule

### design/lcpd_queue.sv
module lcpd_queue import lcpd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_group o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_group             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### design/lcpd_back.sv
module lcpd_back import lcpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_group            i_head,
    output logic              o_pop,
    lcpd_out_if.source        o_out
);

    logic    r_sub, n_sub;
    t_result res;
    logic    is_last;
    logic    fire;

    assign res     = r_sub ? i_head.r1 : i_head.r0;
    assign is_last = r_sub || !i_head.two;
    assign fire    = !i_empty && o_out.ready;
    assign o_pop   = fire && is_last;

    assign o_out.valid        = !i_empty;
    assign o_out.kind         = res.kind;
    assign o_out.payload_byte = res.payload_byte;
    assign o_out.frame_length = res.frame_length;
    assign o_out.last         = is_last;

    always_comb begin
        n_sub = r_sub;
        if (fire) begin
            n_sub = !is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else begin
            r_sub <= n_sub;
        end
    end

endmodule
